// File: sv/srr_pkg.sv
// Shared types and constants for the silence run remover.
`timescale 1ns / 1ps

package srr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 15;
  localparam int DROP_W    = 7;
  localparam int CFG_W     = 15;
  localparam int CFG_ADDR_W = 1;

  localparam int MAX_RUN_DEF = 64;

  localparam logic [LEVEL_W-1:0] LEVEL_RST = '0;
  localparam logic [DROP_W-1:0]  DROP_RST  = 7'd64;

  localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_LEVEL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DROP_LEN  = 1'b1;

  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_SAMPLE = 2'd1,
    TAIL_MARKER = 2'd2
  } tail_e;

  // Control part of one queued command
  typedef struct packed {
    logic  do_store;
    logic  run_final;
    tail_e tail;
    logic  tail_final;
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

// File: sv/srr_front.sv
// Front end: classifies samples, tracks the silent run and issues commands.
`timescale 1ns / 1ps

module srr_front import srr_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF,
  parameter int CW      = $clog2(MAX_RUN + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       stream_end_i,
  input  logic [LEVEL_W-1:0]         silence_level_i,
  input  logic [DROP_W-1:0]          min_drop_len_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output cmd_ctrl_t                  cmd_ctrl_o,
  output logic [SAMPLE_W-1:0]        cmd_sample_o,
  output logic [CW-1:0]              cmd_idx_o,
  output logic [CW-1:0]              cmd_run_len_o
);

  localparam int LW = (CW > DROP_W) ? CW : DROP_W;

  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       cnt_inc;
  logic [LW-1:0]       drop_raw, len;
  logic [SAMPLE_W:0]   mag;
  logic                silent;
  logic                accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;

  // -32768 gives 32768, which never counts as silent
  assign mag    = sample_in_i[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, sample_in_i})
                                          : {1'b0, sample_in_i};
  assign silent = mag <= {2'b00, silence_level_i};

  assign drop_raw = LW'(min_drop_len_i);
  always_comb begin
    if (drop_raw == '0) begin
      len = LW'(1);
    end else if (drop_raw > LW'(MAX_RUN)) begin
      len = LW'(MAX_RUN);
    end else begin
      len = drop_raw;
    end
  end

  assign cnt_inc = (cnt_q < CW'(MAX_RUN)) ? cnt_q + CW'(1) : cnt_q;

  always_comb begin
    cmd_ctrl_o.do_store   = 1'b0;
    cmd_ctrl_o.run_final  = 1'b0;
    cmd_ctrl_o.tail       = TAIL_NONE;
    cmd_ctrl_o.tail_final = 1'b0;
    cmd_sample_o          = sample_in_i;
    cmd_idx_o             = cnt_q;
    cmd_run_len_o         = '0;
    cnt_d                 = cnt_q;
    if (silent) begin
      cmd_ctrl_o.do_store = cnt_q < CW'(MAX_RUN - 1);
      cnt_d               = cnt_inc;
      if (stream_end_i) begin
        cnt_d = '0;
        if (LW'(cnt_inc) < len) begin
          cmd_run_len_o        = cnt_inc;
          cmd_ctrl_o.run_final = 1'b1;
        end else begin
          cmd_ctrl_o.tail       = TAIL_MARKER;
          cmd_ctrl_o.tail_final = 1'b1;
        end
      end
    end else begin
      cnt_d = '0;
      if (LW'(cnt_q) < len) begin
        cmd_run_len_o = cnt_q;
      end
      cmd_ctrl_o.tail       = TAIL_SAMPLE;
      cmd_ctrl_o.tail_final = stream_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/srr_queue.sv
// Small command queue between front and back end.
`timescale 1ns / 1ps

module srr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    num_q;

  assign full_o  = num_q == NW'(DEPTH);
  assign empty_o = num_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        num_q <= num_q + NW'(1);
      end else if (pop_i && !push_i) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

endmodule

// File: sv/srr_back.sv
// Back end: run store, run replay and the output register.
`timescale 1ns / 1ps

module srr_back import srr_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF,
  parameter int CW      = $clog2(MAX_RUN + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  cmd_ctrl_t                   cmd_ctrl_i,
  input  logic [SAMPLE_W-1:0]         cmd_sample_i,
  input  logic [CW-1:0]               cmd_idx_i,
  input  logic [CW-1:0]               cmd_run_len_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        has_sample_o,
  output logic                        final_out_o
);

  localparam int DEPTH = MAX_RUN - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [SAMPLE_W-1:0] store_q [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  logic [1:0]          state_q, state_d;
  cmd_ctrl_t           ctrl_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [CW-1:0]       run_len_q;
  logic [CW-1:0]       idx_q, idx_d;

  logic                out_free;
  logic                out_load;
  logic [SAMPLE_W-1:0] out_sample_d;
  logic                out_has_d, out_final_d;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_has_q, out_final_q;
  logic                rd_en;
  logic                wr_en;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign wr_en    = q_pop_o && cmd_ctrl_i.do_store;
  assign rd_en    = state_q == S_READ;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cmd_idx_i[AW-1:0]] <= cmd_sample_i;
    end
    if (rd_en) begin
      rd_data_q <= store_q[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    out_load     = 1'b0;
    out_sample_d = rd_data_q;
    out_has_d    = 1'b1;
    out_final_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (!q_empty_i) begin
          if (cmd_run_len_i != '0) begin
            state_d = S_READ;
          end else if (cmd_ctrl_i.tail != TAIL_NONE) begin
            state_d = S_TAIL;
          end
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_final_d = ctrl_q.run_final && (idx_q + CW'(1) == run_len_q);
          if (idx_q + CW'(1) == run_len_q) begin
            state_d = (ctrl_q.tail != TAIL_NONE) ? S_TAIL : S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_READ;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_final_d = ctrl_q.tail_final;
          if (ctrl_q.tail == TAIL_SAMPLE) begin
            out_sample_d = sample_q;
          end else begin
            out_sample_d = '0;
            out_has_d    = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ctrl_q    <= cmd_ctrl_i;
      sample_q  <= cmd_sample_i;
      run_len_q <= cmd_run_len_i;
    end
    if (out_load) begin
      out_sample_q <= out_sample_d;
      out_has_q    <= out_has_d;
      out_final_q  <= out_final_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign has_sample_o = out_has_q;
  assign final_out_o  = out_final_q;

endmodule

// File: sv/silence_run_remover_top.sv
// Top level of the silence run remover: config registers, front, queue, back.
// A loud sample with no held run passes the queue, the back end state and the output register.
// Throughput: the front takes one sample a cycle while the 4-deep queue has room;
// the back end pops a silent sample straight away, sends a loud sample or end marker
// through its tail state and replays each run entry by a registered store read, then output.
// Reset clears run count, queue, output valid, level to 0, length to 64; not the run store.
`timescale 1ns / 1ps

module silence_run_remover_top import srr_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic                        stream_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        has_sample_o,
  output logic                        final_out_o
);

  localparam int CW     = $clog2(MAX_RUN + 1);
  localparam int QW     = CTRL_W + SAMPLE_W + 2 * CW;
  localparam int QDEPTH = 4;

  logic [LEVEL_W-1:0]  silence_level_q;
  logic [DROP_W-1:0]   min_drop_len_q;

  logic                q_full, q_empty, q_push, q_pop;
  logic [QW-1:0]       q_din, q_dout;

  cmd_ctrl_t           f_ctrl, b_ctrl;
  logic [SAMPLE_W-1:0] f_sample, b_sample;
  logic [CW-1:0]       f_idx, b_idx, f_len, b_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_level_q <= LEVEL_RST;
      min_drop_len_q  <= DROP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SILENCE_LEVEL: silence_level_q <= cfg_wdata_i[LEVEL_W-1:0];
        REG_MIN_DROP_LEN:  min_drop_len_q  <= cfg_wdata_i[DROP_W-1:0];
        default: ;
      endcase
    end
  end

  srr_front #(
    .MAX_RUN (MAX_RUN),
    .CW      (CW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .stream_end_i    (stream_end_i),
    .silence_level_i (silence_level_q),
    .min_drop_len_i  (min_drop_len_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .cmd_ctrl_o      (f_ctrl),
    .cmd_sample_o    (f_sample),
    .cmd_idx_o       (f_idx),
    .cmd_run_len_o   (f_len)
  );

  assign q_din = {f_ctrl, f_sample, f_idx, f_len};

  srr_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_dout),
    .empty_o (q_empty)
  );

  assign {b_ctrl, b_sample, b_idx, b_len} = q_dout;

  srr_back #(
    .MAX_RUN (MAX_RUN),
    .CW      (CW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .cmd_ctrl_i    (b_ctrl),
    .cmd_sample_i  (b_sample),
    .cmd_idx_i     (b_idx),
    .cmd_run_len_i (b_len),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .has_sample_o  (has_sample_o),
    .final_out_o   (final_out_o)
  );

endmodule

// File: test/testbench.sv
// Self-checking testbench for silence_run_remover_top: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import srr_pkg::*;

  localparam int MAX_RUN      = MAX_RUN_DEF;
  localparam int RANDOM_ITEMS = 235;
  localparam int PHASE_ITEMS  = 40;
  localparam int SETTLE       = 24;
  localparam int HOLD_CYCLES  = 160;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       has;
    logic                       fin;
  } kept_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_SAMPLE,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_ADDR_W-1:0]      addr;
    logic [CFG_W-1:0]           wdata;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       eos;
    kept_t                      want;
  } row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_ADDR_W-1:0]      cfg_addr_i;
  logic [CFG_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                       stream_end_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       has_sample_o;
  logic                       final_out_o;

  silence_run_remover_top #(.MAX_RUN(MAX_RUN)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .stream_end_i(stream_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .has_sample_o(has_sample_o),
    .final_out_o (final_out_o)
  );

  // Predictor state
  logic signed [SAMPLE_W-1:0] held [MAX_RUN-1];
  int                         run_len;
  logic [LEVEL_W-1:0]         level_q;
  logic [DROP_W-1:0]          drop_q;

  kept_t kept_q[$];
  kept_t step_out[$];
  row_t  directed_rows[$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  cfg_writes;
  int  phases;
  int  burst_left;
  bit  pressure;
  bit  hold_req;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int drop_eff();
    int l;
    l = int'(drop_q);
    if (l == 0) l = 1;
    if (l > MAX_RUN) l = MAX_RUN;
    return l;
  endfunction

  // Works out the kept samples caused by one input transfer into step_out.
  task automatic predict_kept(input logic signed [SAMPLE_W-1:0] s, input logic eos);
    int    mag;
    int    len;
    int    i;
    logic  replay;
    step_out.delete();
    mag    = (s < 0) ? -int'(s) : int'(s);
    len    = drop_eff();
    replay = (run_len < len);
    if (mag <= int'(level_q)) begin
      if (run_len < MAX_RUN - 1) held[run_len] = s;
      if (run_len < MAX_RUN) run_len++;
      if (eos) begin
        if (run_len < len) begin
          for (i = 0; i < run_len && i < MAX_RUN - 1; i++)
            step_out.insert(step_out.size(), kept_t'{held[i], 1'b1, (i + 1 == run_len)});
        end else begin
          step_out.insert(step_out.size(), kept_t'{'0, 1'b0, 1'b1});
        end
        run_len = 0;
      end
    end else begin
      if (replay) begin
        for (i = 0; i < run_len && i < MAX_RUN - 1; i++)
          step_out.insert(step_out.size(), kept_t'{held[i], 1'b1, 1'b0});
      end
      step_out.insert(step_out.size(), kept_t'{s, 1'b1, eos});
      run_len = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == REG_SILENCE_LEVEL) level_q = data[LEVEL_W-1:0];
    else drop_q = data[DROP_W-1:0];
    cfg_writes++;
  endtask

  // Waits until every expected result has left, then lets held samples settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic eos,
                              input bit typed, input kept_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      if (!pressure && $urandom_range(3, 0) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(8, 1)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    sample_in_i  <= s;
    stream_end_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_kept(s, eos);
    if (typed) kept_q.insert(kept_q.size(), want);
    else foreach (step_out[k]) kept_q.insert(kept_q.size(), step_out[k]);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic void add_row(row_kind_e kind, logic [CFG_ADDR_W-1:0] addr,
                                  logic [CFG_W-1:0] wdata, logic signed [SAMPLE_W-1:0] smp,
                                  logic eos, kept_t want);
    row_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.wdata = wdata;
    r.smp   = smp;
    r.eos   = eos;
    r.want  = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
    int m;
    m = $urandom_range(int'(level_q), 0);
    return SAMPLE_W'(($urandom_range(1, 0) != 0) ? -m : m);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] loud_sample();
    int m;
    if (int'(level_q) == 32767) return 16'sh8000;
    m = $urandom_range(32768, int'(level_q) + 1);
    if (m == 32768) return 16'sh8000;
    return SAMPLE_W'(($urandom_range(1, 0) != 0) ? -m : m);
  endfunction

  // Result monitor
  always @(posedge clk_i) begin
    kept_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (kept_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sample=%0d has=%0b fin=%0b",
                                sample_out_o, has_sample_o, final_out_o));
      end else begin
        want = kept_q.pop_front();
        if (sample_out_o !== want.smp)
          flag_mismatch($sformatf("sample_out %0d, want %0d", sample_out_o, want.smp));
        if (has_sample_o !== want.has)
          flag_mismatch($sformatf("has_sample %0b, want %0b", has_sample_o, want.has));
        if (final_out_o !== want.fin)
          flag_mismatch($sformatf("final_out %0b, want %0b", final_out_o, want.fin));
      end
    end
  end

  // Receiver: stall pattern is redrawn whenever its random span runs out; one long hold-off on request.
  initial begin
    int stall_mode;
    int pat_left;
    out_stall_i = 1'b0;
    stall_mode  = 0;
    pat_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (pat_left == 0) begin
          stall_mode = $urandom_range(3, 0);
          pat_left   = $urandom_range(40, 8);
        end
        pat_left--;
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(3, 0) == 0);
          2: out_stall_i <= 1'($urandom_range(1, 0));
          default: out_stall_i <= (pat_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Timeout: %0d expected results still outstanding", kept_q.size());
    $display("** silence_run_remover_top: FAILED **");
    $finish;
  end

  initial begin
    int               random_items;
    int               phase_items;
    int               run_target;
    int               i;
    int               pick;
    logic [DROP_W-1:0] len7;
    logic             ended;
    row_t             r;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = REG_SILENCE_LEVEL;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    sample_in_i  = '0;
    stream_end_i = 1'b0;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    cfg_writes   = 0;
    phases       = 0;
    burst_left   = 0;
    pressure     = 1'b0;
    hold_req     = 1'b0;
    run_len      = 0;
    level_q      = LEVEL_RST;
    drop_q       = DROP_RST;
    random_items = 0;

    // Reset values: level 0, length 64. Each row has one obvious result; the 0 row is a silent end sample.
    add_row(ROW_TYPED, '0, '0, 16'sh7FFF, 1'b0, '{16'sh7FFF, 1'b1, 1'b0});
    add_row(ROW_TYPED, '0, '0, 16'sh8000, 1'b1, '{16'sh8000, 1'b1, 1'b1});
    add_row(ROW_TYPED, '0, '0, 16'sh0000, 1'b1, '{16'sh0000, 1'b1, 1'b1});
    add_row(ROW_CFG, REG_SILENCE_LEVEL, 15'h7FFF, '0, 1'b0, '0);
    // Most negative sample stays loud even at the top level
    add_row(ROW_TYPED, '0, '0, 16'sh8000, 1'b0, '{16'sh8000, 1'b1, 1'b0});
    add_row(ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sh8001, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sh1234, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, '0);
    // Length 0 acts as 1: a lone silent end sample gives the marker
    add_row(ROW_CFG, REG_MIN_DROP_LEN, 15'h0000, '0, 1'b0, '0);
    add_row(ROW_TYPED, '0, '0, 16'sh0005, 1'b1, '{16'sh0000, 1'b0, 1'b1});
    add_row(ROW_CFG, REG_SILENCE_LEVEL, 15'd100, '0, 1'b0, '0);
    add_row(ROW_CFG, REG_MIN_DROP_LEN, 15'd3, '0, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sh0003, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, -16'sd3, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd100, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd101, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd7, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, -16'sd100, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, -16'sd101, 1'b1, '0);
    // Length lowered while a run is held
    add_row(ROW_CFG, REG_MIN_DROP_LEN, 15'd2, '0, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd0, 1'b0, '0);
    add_row(ROW_CFG, REG_MIN_DROP_LEN, 15'd1, '0, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd0, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd200, 1'b1, '0);
    // Upper data bits ignored; 127 acts as the maximum run
    add_row(ROW_CFG, REG_MIN_DROP_LEN, 15'h7FFF, '0, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd1, 1'b0, '0);
    add_row(ROW_SAMPLE, '0, '0, 16'sd2000, 1'b1, '0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[n]) begin
      r = directed_rows[n];
      if (r.kind == ROW_CFG) begin
        drain();
        write_reg(r.addr, r.wdata);
      end else begin
        offer_sample(r.smp, r.eos, r.kind == ROW_TYPED, r.want);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      drain();
      case (phases)
        0: begin
          write_reg(REG_SILENCE_LEVEL, 15'd0);
          write_reg(REG_MIN_DROP_LEN, 15'd1);
        end
        1: begin
          write_reg(REG_SILENCE_LEVEL, 15'h7FFF);
          write_reg(REG_MIN_DROP_LEN, 15'd64);
        end
        default: begin
          write_reg(REG_SILENCE_LEVEL, CFG_W'(($urandom_range(1, 0) != 0) ?
                    $urandom_range(300, 0) : $urandom_range(32767, 0)));
          pick = $urandom_range(9, 0);
          if (pick < 3) len7 = DROP_W'($urandom_range(8, 1));
          else if (pick < 5) len7 = DROP_W'($urandom_range(64, 63));
          else if (pick == 5) len7 = 7'd0;
          else if (pick == 6) len7 = DROP_W'($urandom_range(127, 65));
          else len7 = DROP_W'($urandom_range(64, 1));
          write_reg(REG_MIN_DROP_LEN, {8'($urandom_range(255, 0)), len7});
        end
      endcase
      phases++;

      phase_items = 0;
      if (phases == 3) begin
        // Receiver holds off while loud samples keep coming back to back
        hold_req = 1'b1;
        pressure = 1'b1;
        for (i = 0; i < 30; i++) offer_sample(loud_sample(), 1'b0, 1'b0, '0);
        pressure = 1'b0;
        phase_items  += 30;
        random_items += 30;
      end

      while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
        if ($urandom_range(9, 0) < 7) begin
          // Silent run, then a loud sample unless the run ended the stream; lengths clustered around the drop point
          pick = $urandom_range(9, 0);
          if (pick < 4) run_target = $urandom_range(4, 0);
          else if (pick < 8) run_target = drop_eff() - 1 + $urandom_range(2, 0);
          else run_target = $urandom_range(70, 0);
          ended = 1'b0;
          for (i = 0; i < run_target; i++) begin
            ended = (i + 1 == run_target) && ($urandom_range(3, 0) == 0);
            offer_sample(quiet_sample(), ended, 1'b0, '0);
          end
          if (!ended) begin
            offer_sample(loud_sample(), $urandom_range(3, 0) == 0, 1'b0, '0);
            run_target++;
          end
          phase_items  += run_target;
          random_items += run_target;
        end else begin
          offer_sample(SAMPLE_W'($urandom_range(65535, 0)), $urandom_range(7, 0) == 0,
                       1'b0, '0);
          phase_items++;
          random_items++;
        end
      end
    end

    drain();
    $display("Run covered %0d directed rows and %0d random transfers over %0d phases",
             directed_rows.size(), random_items, phases);
    $display("%0d input transfers, %0d results checked, %0d register writes, %0d mismatches",
             items_sent, results_seen, cfg_writes, errors);
    if (errors == 0) begin
      $display("** silence_run_remover_top: PASSED **");
    end else begin
      $display("** silence_run_remover_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: silence_run_remover_top.f
sv/srr_pkg.sv
sv/srr_front.sv
sv/srr_queue.sv
sv/srr_back.sv
sv/silence_run_remover_top.sv
test/testbench.sv
